// ----- src/tedq_pkg.sv -----
`timescale 1ns / 1ps

package tedq_pkg;

   localparam int MODE_W  = 3;
   localparam int TIME_W  = 32;
   localparam int DELTA_W = 16;
   localparam int KEY_W   = 10;
   localparam int DELAY_W = 10;
   localparam int SUM_W   = 27;
   localparam int KIND_W  = 2;
   localparam int DATA_W  = 32;
   localparam int ENTRY_W = TIME_W + KIND_W + DATA_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [DELAY_W-1:0] DELAY_CAP_MS = DELAY_W'(1000);

   localparam logic [MODE_W-1:0] MODE_MOVE   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_BUTTON = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WHEEL  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DRAIN  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

   localparam logic [KIND_W-1:0] KIND_MOVE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WHEEL  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_DELAY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_UP_KEY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_DOWN_KEY = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_RELEASE,
      ST_TOTAL
   } ctrl_state_type;

   typedef struct packed {
      logic enq;
      logic clear;
      logic drain_start;
      logic rd_en;
      logic acc;
      logic pop;
      logic emit_button;
      logic emit_press;
      logic emit_release;
      logic emit_total;
   } ctrl_cmd_type;

   typedef struct packed {
      logic              empty;
      logic              due;
      logic [KIND_W-1:0] kind;
      logic              out_free;
   } ctrl_status_type;

endpackage

// ----- src/tedq_chan_if.sv -----
`timescale 1ns / 1ps

interface tedq_req_if
   import tedq_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [MODE_W-1:0]         mode;
   logic [TIME_W-1:0]         now_ms;
   logic signed [DELTA_W-1:0] move_x;
   logic signed [DELTA_W-1:0] move_y;
   logic [KEY_W-1:0]          key_code;
   logic                      key_down;
   logic                      wheel_up;

   modport source (output valid, mode, now_ms, move_x, move_y, key_code, key_down,
                   wheel_up, input ready);
   modport sink (input valid, mode, now_ms, move_x, move_y, key_code, key_down,
                 wheel_up, output ready);
endinterface

interface tedq_rsp_if
   import tedq_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic                    result_kind;
   logic [KEY_W-1:0]        event_key;
   logic                    event_down;
   logic signed [SUM_W-1:0] sum_x;
   logic signed [SUM_W-1:0] sum_y;
   logic                    last;

   modport source (output valid, result_kind, event_key, event_down, sum_x, sum_y,
                   last, input ready);
   modport sink (input valid, result_kind, event_key, event_down, sum_x, sum_y,
                 last, output ready);
endinterface

interface tedq_csr_if
   import tedq_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DELAY_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- src/tedq_ram.sv -----
`timescale 1ns / 1ps

module tedq_ram #(
   parameter int WIDTH = 66,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/tedq_ctrl.sv -----
`timescale 1ns / 1ps

module tedq_ctrl
   import tedq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [MODE_W-1:0] req_mode,
   output logic              req_ready,
   input  ctrl_status_type   status,
   output ctrl_cmd_type      cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_mode)
                  MODE_MOVE, MODE_BUTTON, MODE_WHEEL: begin
                     cmd.enq = 1'b1;
                  end
                  MODE_DRAIN: begin
                     cmd.drain_start = 1'b1;
                     state_in        = ST_READ;
                  end
                  MODE_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            if (status.empty) begin
               state_in = ST_TOTAL;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.due) begin
               state_in = ST_TOTAL;
            end else begin
               case (status.kind)
                  KIND_MOVE: begin
                     cmd.acc  = 1'b1;
                     cmd.pop  = 1'b1;
                     state_in = ST_READ;
                  end
                  KIND_BUTTON: begin
                     if (status.out_free) begin
                        cmd.emit_button = 1'b1;
                        cmd.pop         = 1'b1;
                        state_in        = ST_READ;
                     end
                  end
                  KIND_WHEEL: begin
                     if (status.out_free) begin
                        cmd.emit_press = 1'b1;
                        state_in       = ST_RELEASE;
                     end
                  end
                  default: begin
                     cmd.pop  = 1'b1;
                     state_in = ST_READ;
                  end
               endcase
            end
         end
         ST_RELEASE: begin
            if (status.out_free) begin
               cmd.emit_release = 1'b1;
               cmd.pop          = 1'b1;
               state_in         = ST_READ;
            end
         end
         ST_TOTAL: begin
            if (status.out_free) begin
               cmd.emit_total = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- src/tedq_datapath.sv -----
`timescale 1ns / 1ps

module tedq_datapath
   import tedq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_cmd_type              cmd,
   output ctrl_status_type           status,
   input  logic [MODE_W-1:0]         req_mode,
   input  logic [TIME_W-1:0]         req_now_ms,
   input  logic signed [DELTA_W-1:0] req_move_x,
   input  logic signed [DELTA_W-1:0] req_move_y,
   input  logic [KEY_W-1:0]          req_key_code,
   input  logic                      req_key_down,
   input  logic                      req_wheel_up,
   input  logic                      csr_valid,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [DELAY_W-1:0]        csr_data,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic                      rsp_result_kind,
   output logic [KEY_W-1:0]          rsp_event_key,
   output logic                      rsp_event_down,
   output logic signed [SUM_W-1:0]   rsp_sum_x,
   output logic signed [SUM_W-1:0]   rsp_sum_y,
   output logic                      rsp_last
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   logic [DELAY_W-1:0] release_delay_ff;
   logic [KEY_W-1:0]   wheel_up_key_ff;
   logic [KEY_W-1:0]   wheel_down_key_ff;

   logic [IDX_W-1:0] write_pos_ff, write_pos_in;
   logic [IDX_W-1:0] read_pos_ff, read_pos_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   logic [TIME_W-1:0]  drain_now_ff;
   logic [DELAY_W-1:0] drain_delay_ff;
   logic signed [SUM_W-1:0] sum_x_ff, sum_y_ff;

   logic [KIND_W-1:0]  enq_kind;
   logic [DATA_W-1:0]  enq_data;
   logic [ENTRY_W-1:0] wr_entry;
   logic [ENTRY_W-1:0] rd_entry;
   logic [TIME_W-1:0]  ent_time;
   logic [KIND_W-1:0]  ent_kind;
   logic [DATA_W-1:0]  ent_data;
   logic [TIME_W-1:0]  age;
   logic [KEY_W-1:0]   wheel_key;

   logic                    rsp_valid_ff;
   logic                    rsp_kind_ff;
   logic [KEY_W-1:0]        rsp_key_ff;
   logic                    rsp_down_ff;
   logic signed [SUM_W-1:0] rsp_sum_x_ff, rsp_sum_y_ff;
   logic                    rsp_last_ff;
   logic                    out_free;

   function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] pos);
      return (pos == LAST_IDX) ? '0 : pos + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         release_delay_ff  <= '0;
         wheel_up_key_ff   <= '0;
         wheel_down_key_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RELEASE_DELAY:  release_delay_ff  <= csr_data;
            CSR_WHEEL_UP_KEY:   wheel_up_key_ff   <= csr_data;
            CSR_WHEEL_DOWN_KEY: wheel_down_key_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      enq_kind = KIND_MOVE;
      enq_data = {req_move_y, req_move_x};
      case (req_mode)
         MODE_BUTTON: begin
            enq_kind = KIND_BUTTON;
            enq_data = {(DATA_W - KEY_W - 1)'(0), req_key_down, req_key_code};
         end
         MODE_WHEEL: begin
            enq_kind = KIND_WHEEL;
            enq_data = {(DATA_W - 1)'(0), req_wheel_up};
         end
         default: begin
         end
      endcase
   end

   assign wr_entry = {req_now_ms, enq_kind, enq_data};

   tedq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.enq),
      .wr_addr (write_pos_ff),
      .wr_data (wr_entry),
      .rd_en   (cmd.rd_en),
      .rd_addr (read_pos_ff),
      .rd_data (rd_entry)
   );

   assign {ent_time, ent_kind, ent_data} = rd_entry;

   always_comb begin
      write_pos_in = write_pos_ff;
      read_pos_in  = read_pos_ff;
      fill_in      = fill_ff;
      if (cmd.clear) begin
         write_pos_in = '0;
         read_pos_in  = '0;
         fill_in      = '0;
      end else if (cmd.enq) begin
         write_pos_in = next_pos(write_pos_ff);
         if (fill_ff == FULL_CNT) begin
            read_pos_in = next_pos(read_pos_ff);
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end else if (cmd.pop) begin
         read_pos_in = next_pos(read_pos_ff);
         fill_in     = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_pos_ff <= '0;
         read_pos_ff  <= '0;
         fill_ff      <= '0;
      end else begin
         write_pos_ff <= write_pos_in;
         read_pos_ff  <= read_pos_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.drain_start) begin
         drain_now_ff   <= req_now_ms;
         drain_delay_ff <= (release_delay_ff > DELAY_CAP_MS) ? DELAY_CAP_MS
                                                             : release_delay_ff;
         sum_x_ff       <= '0;
         sum_y_ff       <= '0;
      end else if (cmd.acc) begin
         sum_x_ff <= sum_x_ff + SUM_W'(signed'(ent_data[DELTA_W-1:0]));
         sum_y_ff <= sum_y_ff + SUM_W'(signed'(ent_data[2*DELTA_W-1:DELTA_W]));
      end
   end

   assign age       = drain_now_ff - ent_time;
   assign wheel_key = ent_data[0] ? wheel_up_key_ff : wheel_down_key_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign status.empty    = (fill_ff == '0);
   assign status.due      = (age >= {(TIME_W - DELAY_W)'(0), drain_delay_ff});
   assign status.kind     = ent_kind;
   assign status.out_free = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_button || cmd.emit_press || cmd.emit_release
                   || cmd.emit_total) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_button) begin
         rsp_kind_ff  <= 1'b0;
         rsp_key_ff   <= ent_data[KEY_W-1:0];
         rsp_down_ff  <= ent_data[KEY_W];
         rsp_sum_x_ff <= '0;
         rsp_sum_y_ff <= '0;
         rsp_last_ff  <= 1'b0;
      end else if (cmd.emit_press || cmd.emit_release) begin
         rsp_kind_ff  <= 1'b0;
         rsp_key_ff   <= wheel_key;
         rsp_down_ff  <= cmd.emit_press;
         rsp_sum_x_ff <= '0;
         rsp_sum_y_ff <= '0;
         rsp_last_ff  <= 1'b0;
      end else if (cmd.emit_total) begin
         rsp_kind_ff  <= 1'b1;
         rsp_key_ff   <= '0;
         rsp_down_ff  <= 1'b0;
         rsp_sum_x_ff <= sum_x_ff;
         rsp_sum_y_ff <= sum_y_ff;
         rsp_last_ff  <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_event_key   = rsp_key_ff;
   assign rsp_event_down  = rsp_down_ff;
   assign rsp_sum_x       = rsp_sum_x_ff;
   assign rsp_sum_y       = rsp_sum_y_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ----- src/timestamped_event_delay_queue.sv -----
// Ring queue of timestamped input events with delayed release.
// The req_chan channel carries one item per transfer: a move, button or wheel
// event to enqueue, stamped with now_ms, a drain, or a clear. When the ring
// is full, an enqueue overwrites the oldest entry. An enqueue or a clear
// leaves the block idle, and req_chan stays ready for another item.
// A drain walks the ring oldest first and releases entries while their age
// is at least the configured release delay (capped at 1000 ms), and stops at
// the first entry that is not yet due. Each entry passes a ring memory read
// and then an age compare, and a wheel entry adds a release step, since it
// gives a press and then a release transfer. A drain always ends with a
// movement total with last set, and the total is valid in the cycle in which
// req_chan is ready again.
// Results leave through an output register on rsp_chan. When the receiver
// stalls, the drain waits on the pending result, and req_chan stays not ready
// until the drain has finished. Configuration writes on csr_chan are always
// accepted and must only be made while the block is idle.
// Reset empties the queue and clears the configuration registers to zero.
`timescale 1ns / 1ps

module timestamped_event_delay_queue
   import tedq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   tedq_req_if.sink   req_chan,
   tedq_rsp_if.source rsp_chan,
   tedq_csr_if.sink   csr_chan
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_chan.ready = 1'b1;

   tedq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tedq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_mode        (req_chan.mode),
      .req_now_ms      (req_chan.now_ms),
      .req_move_x      (req_chan.move_x),
      .req_move_y      (req_chan.move_y),
      .req_key_code    (req_chan.key_code),
      .req_key_down    (req_chan.key_down),
      .req_wheel_up    (req_chan.wheel_up),
      .csr_valid       (csr_chan.valid),
      .csr_index       (csr_chan.index),
      .csr_data        (csr_chan.data),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_result_kind (rsp_chan.result_kind),
      .rsp_event_key   (rsp_chan.event_key),
      .rsp_event_down  (rsp_chan.event_down),
      .rsp_sum_x       (rsp_chan.sum_x),
      .rsp_sum_y       (rsp_chan.sum_y),
      .rsp_last        (rsp_chan.last)
   );

endmodule
